@@ hw/rtl/rsrz_pkg.sv @@
// ----------------------------------------------------------------------------
// rsrz_pkg
// Shared types and constants of the rotate-zoom sprite sampler: command and
// register codes, datapath widths, the configuration bundle and the
// luminance table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsrz_pkg;

  // Command codes carried by cmd_i
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_ZOOM   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE  = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the registers
  localparam logic [10:0]        OUT_WIDTH_RST  = 11'd80;
  localparam logic [10:0]        OUT_HEIGHT_RST = 11'd50;
  localparam logic [12:0]        INV_ZOOM_RST   = 13'd256;
  localparam logic signed [15:0] COS_ANGLE_RST  = 16'sd16384;
  localparam logic signed [15:0] SIN_ANGLE_RST  = 16'sd0;

  // Zoom floor of 0.05 gives this largest usable inverse zoom
  localparam logic [12:0] INV_ZOOM_MAX = 13'd5120;

  // Sprite pixel (palette index) width
  localparam int unsigned PIX_W = 3;

  // Datapath widths
  localparam int unsigned AX_W      = 12;  // 2*px - w
  localparam int unsigned AY_W      = 13;  // 2*(2*py - h)
  localparam int unsigned Z_W       = 14;  // clamped zoom, sign bit added
  localparam int unsigned PROD_W    = 30;  // rotated sums
  localparam int unsigned ZP_W      = 44;  // after the zoom product
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned Q_W       = ZP_W - FRAC_BITS;
  localparam int unsigned SRC_W     = Q_W + 1;
  localparam logic [ZP_W-1:0] TRUNC_BIAS = ZP_W'((64'd1 << FRAC_BITS) - 64'd1);

  typedef struct packed {
    logic [10:0]        out_width;
    logic [10:0]        out_height;
    logic [12:0]        inv_zoom;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
  } cfg_t;

  // Luminance by palette index; indices above five read as black
  localparam logic [7:0] LUM_TABLE [8] = '{
    8'd0, 8'd25, 8'd255, 8'd205, 8'd165, 8'd105, 8'd0, 8'd0
  };

endpackage

`default_nettype wire

@@ hw/rtl/rle_sprite_rotozoom_sampler_core.sv @@
// ----------------------------------------------------------------------------
// rle_sprite_rotozoom_sampler_core
// Run-length sprite loader and rotate-zoom nearest-neighbour sampler.
//
// Usage: items arrive on the input channel (in_valid_i / in_stall_o). A load
// transaction (cmd_i = 0) writes run_length_i pixels of palette_index_i into
// the sprite store in raster order, one pixel per cycle, and yields no result.
// Pixels past the last row are dropped. A sample transaction (cmd_i = 1) maps
// pixel_x_i / pixel_y_i into sprite space and yields one result (hit_o,
// luminance_o) on the output channel (out_valid_o / out_stall_i). The block
// takes one item at a time and stalls its input until that item is done; a
// sample passes the four-step multiply sequence in the map unit and one sprite
// store read. The user must write registers through cfg_valid_i / cfg_ready_o
// only between transactions, while nothing is in flight; the block does not
// enforce this, and cfg_ready_o is always high.
// Reset leaves the store empty: a fill pointer marks how far loading has got
// and anything beyond it reads as palette index 0, so no clearing pass runs.
// When the receiver stalls, the result waits in the output register while
// the next item is still accepted; a second result waits in the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rle_sprite_rotozoom_sampler_core #(
  parameter int unsigned SPRITE_W = 64,
  parameter int unsigned SPRITE_H = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Item channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               cmd_i,
  input  wire logic [2:0]                         palette_index_i,
  input  wire logic [7:0]                         run_length_i,
  input  wire logic [9:0]                         pixel_x_i,
  input  wire logic [9:0]                         pixel_y_i,
  // Result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    hit_o,
  output logic [7:0]                              luminance_o,
  // Register write channel
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rsrz_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [rsrz_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned Depth = SPRITE_W * SPRITE_H;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PtrW  = $clog2(Depth + 1);
  localparam int unsigned ColW  = $clog2(SPRITE_W);
  localparam int unsigned RowW  = $clog2(SPRITE_H);

  typedef enum logic [1:0] {
    T_IDLE,
    T_LOAD,
    T_MAP,
    T_RESP
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  rsrz_pkg::cfg_t cfg_q;

  // Loader
  logic [PtrW-1:0]            ptr_q;      // next raster position, fill mark
  logic [7:0]                 run_q;
  logic [rsrz_pkg::PIX_W-1:0] idx_q;
  logic                       full;

  // Sampler
  logic                       map_done;
  logic                       map_inside;
  logic [ColW-1:0]            map_col;
  logic [RowW-1:0]            map_row;
  logic [AddrW-1:0]           rd_addr;
  logic                       hit_pend_q;
  logic                       fill_ok_q;
  logic [rsrz_pkg::PIX_W-1:0] rd_data;

  // Output register
  logic                       out_valid_q;
  logic                       hit_q;
  logic [7:0]                 lum_q;
  logic [7:0]                 lum_next;

  logic accept, map_start, wr_en, rd_en, push;

  // --------------------------------------------------------------------------
  // Register writes: always ready, unknown indexes drop silently
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_width  <= rsrz_pkg::OUT_WIDTH_RST;
      cfg_q.out_height <= rsrz_pkg::OUT_HEIGHT_RST;
      cfg_q.inv_zoom   <= rsrz_pkg::INV_ZOOM_RST;
      cfg_q.cos_angle  <= rsrz_pkg::COS_ANGLE_RST;
      cfg_q.sin_angle  <= rsrz_pkg::SIN_ANGLE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rsrz_pkg::REG_OUT_WIDTH:  cfg_q.out_width  <= cfg_data_i[10:0];
        rsrz_pkg::REG_OUT_HEIGHT: cfg_q.out_height <= cfg_data_i[10:0];
        rsrz_pkg::REG_INV_ZOOM:   cfg_q.inv_zoom   <= cfg_data_i[12:0];
        rsrz_pkg::REG_COS_ANGLE:  cfg_q.cos_angle  <= $signed(cfg_data_i);
        rsrz_pkg::REG_SIN_ANGLE:  cfg_q.sin_angle  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and sequencing: one item in flight at a time
  // --------------------------------------------------------------------------
  assign in_stall_o = (state_q != T_IDLE);
  assign accept     = in_valid_i && (state_q == T_IDLE);
  assign map_start  = accept && (cmd_i == rsrz_pkg::CMD_SAMPLE);
  assign full       = (ptr_q == PtrW'(Depth));
  assign wr_en      = (state_q == T_LOAD) && (run_q != 8'd0) && !full;
  assign rd_en      = (state_q == T_MAP) && map_done;
  assign push       = (state_q == T_RESP) && (!out_valid_q || !out_stall_i);

  // Raster address of the mapped source pixel
  assign rd_addr = AddrW'(AddrW'(map_row) * AddrW'(SPRITE_W)) + AddrW'(map_col);

  // Entries beyond the fill mark have never been written and read as index 0
  assign lum_next = (hit_pend_q && fill_ok_q) ? rsrz_pkg::LUM_TABLE[rd_data] : 8'd0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          state_d = (cmd_i == rsrz_pkg::CMD_SAMPLE) ? T_MAP : T_LOAD;
        end
      end
      T_LOAD: begin
        // Leave once the run is spent or the sprite is full
        if (run_q == 8'd0 || full) state_d = T_IDLE;
      end
      T_MAP: begin
        if (map_done) state_d = T_RESP;
      end
      T_RESP: begin
        if (push) state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      lum_q       <= 8'd0;
    end else begin
      state_q <= state_d;
      if (push) begin
        out_valid_q <= 1'b1;
        hit_q       <= hit_pend_q;
        lum_q       <= lum_next;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Loader cursor and remaining run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      run_q <= 8'd0;
    end else begin
      if (accept && cmd_i == rsrz_pkg::CMD_LOAD) begin
        run_q <= run_length_i;
      end else if (wr_en) begin
        run_q <= run_q - 8'd1;
      end
      if (wr_en) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
    end
  end

  // Payload held alongside the sequence
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i == rsrz_pkg::CMD_LOAD) begin
      idx_q <= palette_index_i;
    end
    if (rd_en) begin
      hit_pend_q <= map_inside;
      fill_ok_q  <= (PtrW'(rd_addr) < ptr_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign luminance_o = lum_q;

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  rsrz_map_unit #(
    .SPRITE_W (SPRITE_W),
    .SPRITE_H (SPRITE_H)
  ) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (map_start),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cfg_i     (cfg_q),
    .done_o    (map_done),
    .inside_o  (map_inside),
    .col_o     (map_col),
    .row_o     (map_row)
  );

  rsrz_sprite_ram #(
    .DEPTH (Depth)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (ptr_q[AddrW-1:0]),
    .wr_data_i (idx_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PtrW'(Depth))
    else $error("fill pointer ran past the sprite");

  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q != $past(ptr_q)) |-> (ptr_q == $past(ptr_q) + PtrW'(1)))
    else $error("fill pointer moved by other than one");

  a_done_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_done |-> (state_q == T_MAP))
    else $error("map unit finished outside a sample transaction");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == T_RESP))
    else $error("result appeared without a pending sample");

endmodule

`default_nettype wire

@@ hw/rtl/rsrz_sprite_ram.sv @@
// ----------------------------------------------------------------------------
// rsrz_sprite_ram
// Sprite store: one write port, one read port, registered read data that
// holds until the next read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsrz_sprite_ram #(
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  wire logic [rsrz_pkg::PIX_W-1:0]   wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic      [rsrz_pkg::PIX_W-1:0]   rd_data_o
);

  logic [rsrz_pkg::PIX_W-1:0] mem_q [DEPTH];
  logic [rsrz_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/rsrz_map_unit.sv @@
// ----------------------------------------------------------------------------
// rsrz_map_unit
// Maps an output pixel back into sprite space: centre, rotate, scale by the
// inverse zoom, truncate toward zero and offset by the sprite centre.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsrz_map_unit #(
  parameter int unsigned SPRITE_W = 64,
  parameter int unsigned SPRITE_H = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [9:0]                   pixel_x_i,
  input  wire logic [9:0]                   pixel_y_i,
  input  wire rsrz_pkg::cfg_t               cfg_i,
  output logic                              done_o,
  output logic                              inside_o,
  output logic [$clog2(SPRITE_W)-1:0]       col_o,
  output logic [$clog2(SPRITE_H)-1:0]       row_o
);

  localparam int unsigned ColW  = $clog2(SPRITE_W);
  localparam int unsigned RowW  = $clog2(SPRITE_H);
  localparam int unsigned HalfW = SPRITE_W / 2;
  localparam int unsigned HalfH = SPRITE_H / 2;

  typedef enum logic [2:0] {
    M_IDLE,
    M_PROD,
    M_SUM,
    M_ZOOM,
    M_MAP
  } state_e;

  state_e state_q, state_d;

  logic                                    done_q;
  logic                                    inside_q;
  logic [ColW-1:0]                         col_q;
  logic [RowW-1:0]                         row_q;

  logic signed [rsrz_pkg::AX_W-1:0]        ax_q, ax_d;
  logic signed [rsrz_pkg::AY_W-1:0]        ay_q, ay_d;
  logic signed [rsrz_pkg::Z_W-1:0]         z_q, z_d;
  logic signed [rsrz_pkg::PROD_W-1:0]      pa_q, pa_d, pb_q, pb_d;
  logic signed [rsrz_pkg::PROD_W-1:0]      n_q, n_d, m_q, m_d;
  logic signed [rsrz_pkg::ZP_W-1:0]        nz_q, nz_d, mz_q, mz_d;

  logic signed [11:0]                      dy;
  logic [12:0]                             zc;
  logic signed [rsrz_pkg::ZP_W-1:0]        rnd_n, rnd_m;
  logic signed [rsrz_pkg::Q_W-1:0]         tn, tm;
  logic signed [rsrz_pkg::SRC_W-1:0]       sx, sy;
  logic                                    in_x, in_y;

  // Centre and clamp on start
  always_comb begin
    ax_d = $signed({1'b0, pixel_x_i, 1'b0}) - $signed({1'b0, cfg_i.out_width});
    dy   = $signed({1'b0, pixel_y_i, 1'b0}) - $signed({1'b0, cfg_i.out_height});
    ay_d = $signed({dy, 1'b0});
    zc   = (cfg_i.inv_zoom > rsrz_pkg::INV_ZOOM_MAX) ? rsrz_pkg::INV_ZOOM_MAX
                                                     : cfg_i.inv_zoom;
    z_d  = $signed({1'b0, zc});
  end

  // Rotate, then scale
  always_comb begin
    pa_d = rsrz_pkg::PROD_W'(ax_q) * rsrz_pkg::PROD_W'(cfg_i.cos_angle);
    pb_d = rsrz_pkg::PROD_W'(ax_q) * rsrz_pkg::PROD_W'(cfg_i.sin_angle);
    n_d  = pa_q - rsrz_pkg::PROD_W'(ay_q) * rsrz_pkg::PROD_W'(cfg_i.sin_angle);
    m_d  = pb_q + rsrz_pkg::PROD_W'(ay_q) * rsrz_pkg::PROD_W'(cfg_i.cos_angle);
    nz_d = rsrz_pkg::ZP_W'(n_q) * rsrz_pkg::ZP_W'(z_q);
    mz_d = rsrz_pkg::ZP_W'(m_q) * rsrz_pkg::ZP_W'(z_q);
  end

  // Truncate toward zero: bias negative values before the arithmetic shift
  always_comb begin
    rnd_n = nz_q + $signed(nz_q[rsrz_pkg::ZP_W-1] ? rsrz_pkg::TRUNC_BIAS
                                                   : {rsrz_pkg::ZP_W{1'b0}});
    rnd_m = mz_q + $signed(mz_q[rsrz_pkg::ZP_W-1] ? rsrz_pkg::TRUNC_BIAS
                                                   : {rsrz_pkg::ZP_W{1'b0}});
    tn    = rnd_n[rsrz_pkg::ZP_W-1:rsrz_pkg::FRAC_BITS];
    tm    = rnd_m[rsrz_pkg::ZP_W-1:rsrz_pkg::FRAC_BITS];
    sx    = rsrz_pkg::SRC_W'(tn) + rsrz_pkg::SRC_W'(HalfW);
    sy    = rsrz_pkg::SRC_W'(tm) + rsrz_pkg::SRC_W'(HalfH);
    in_x  = !sx[rsrz_pkg::SRC_W-1] && (sx < rsrz_pkg::SRC_W'(SPRITE_W));
    in_y  = !sy[rsrz_pkg::SRC_W-1] && (sy < rsrz_pkg::SRC_W'(SPRITE_H));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      M_IDLE: if (start_i) state_d = M_PROD;
      M_PROD: state_d = M_SUM;
      M_SUM:  state_d = M_ZOOM;
      M_ZOOM: state_d = M_MAP;
      M_MAP:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= M_IDLE;
      done_q   <= 1'b0;
      inside_q <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == M_MAP);
      if (state_q == M_MAP) begin
        inside_q <= in_x && in_y;
        col_q    <= sx[ColW-1:0];
        row_q    <= sy[RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == M_IDLE && start_i) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      z_q  <= z_d;
    end
    if (state_q == M_PROD) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (state_q == M_SUM) begin
      n_q <= n_d;
      m_q <= m_d;
    end
    if (state_q == M_ZOOM) begin
      nz_q <= nz_d;
      mz_q <= mz_d;
    end
  end

  assign done_o   = done_q;
  assign inside_o = inside_q;
  assign col_o    = col_q;
  assign row_o    = row_q;

endmodule

`default_nettype wire

@@ verif/rle_sprite_rotozoom_sampler_checker.sv @@
// ----------------------------------------------------------------------------
// rle_sprite_rotozoom_sampler_checker
// Passive checker for the rotate-zoom sprite sampler. It watches the register,
// item and result channels and keeps its own copy of the sprite and the
// registers. It predicts the hit and luminance of every accepted sample and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rle_sprite_rotozoom_sampler_checker #(
  parameter int unsigned SPRITE_W = 64,
  parameter int unsigned SPRITE_H = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [2:0]                        palette_index_i,
  input  logic [7:0]                        run_length_i,
  input  logic [9:0]                        pixel_x_i,
  input  logic [9:0]                        pixel_y_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  logic                              hit_o,
  input  logic [7:0]                        luminance_o,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [rsrz_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rsrz_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o,
  output int unsigned                       compared_o,
  output int unsigned                       hits_o
);

  localparam int unsigned STORE_DEPTH = SPRITE_W * SPRITE_H;
  // Keep the sprite bounds signed so that negative source positions compare
  localparam longint SPAN_W  = SPRITE_W;
  localparam longint SPAN_H  = SPRITE_H;
  localparam longint HALF_W  = SPRITE_W / 2;
  localparam longint HALF_H  = SPRITE_H / 2;
  localparam longint Q24_ONE = 64'sd16777216;

  localparam logic [7:0] LUMA_OF_INDEX [8] = '{
    8'd0, 8'd25, 8'd255, 8'd205, 8'd165, 8'd105, 8'd0, 8'd0
  };

  typedef struct packed {
    logic       hit;
    logic [7:0] luminance;
  } pixel_result_t;

  logic [2:0]         sprite_pix [STORE_DEPTH];
  int unsigned        fill_col;
  int unsigned        fill_row;
  logic [10:0]        width_q;
  logic [10:0]        height_q;
  logic [12:0]        zoom_q;
  logic signed [15:0] cos_q;
  logic signed [15:0] sin_q;
  pixel_result_t      expected_q [$];
  int unsigned        fails;
  int unsigned        compared;
  int unsigned        hits;

  // Write a run in raster order; drop whatever falls past the last row
  function automatic void paint_run(logic [2:0] pal, logic [7:0] run);
    int unsigned left;
    left = 32'(run);
    while (left > 0 && fill_row < SPRITE_H) begin
      sprite_pix[fill_row * SPRITE_W + fill_col] = pal;
      left--;
      fill_col++;
      if (fill_col == SPRITE_W) begin
        fill_col = 0;
        fill_row++;
      end
    end
  endfunction

  function automatic pixel_result_t sample_pixel(logic [9:0] px, logic [9:0] py);
    longint        zoom;
    longint        ax;
    longint        ay;
    longint        c;
    longint        s;
    longint        n;
    longint        m;
    longint        sx;
    longint        sy;
    pixel_result_t r;
    zoom = (zoom_q > rsrz_pkg::INV_ZOOM_MAX) ? longint'(rsrz_pkg::INV_ZOOM_MAX)
                                             : longint'(zoom_q);
    ax   = 2 * longint'(px) - longint'(width_q);
    ay   = 2 * (2 * longint'(py) - longint'(height_q));
    c    = cos_q;
    s    = sin_q;
    n    = zoom * (ax * c - ay * s);
    m    = zoom * (ax * s + ay * c);
    // Signed division truncates toward zero
    sx   = n / Q24_ONE + HALF_W;
    sy   = m / Q24_ONE + HALF_H;
    r.hit       = (sx >= 0) && (sx < SPAN_W) && (sy >= 0) && (sy < SPAN_H);
    r.luminance = r.hit ? LUMA_OF_INDEX[sprite_pix[sy * SPAN_W + sx]] : 8'd0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pixel_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < STORE_DEPTH; i++) sprite_pix[i] = '0;
      fill_col = 0;
      fill_row = 0;
      width_q  = rsrz_pkg::OUT_WIDTH_RST;
      height_q = rsrz_pkg::OUT_HEIGHT_RST;
      zoom_q   = rsrz_pkg::INV_ZOOM_RST;
      cos_q    = rsrz_pkg::COS_ANGLE_RST;
      sin_q    = rsrz_pkg::SIN_ANGLE_RST;
      expected_q.delete();
      fails    = 0;
      compared = 0;
      hits     = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      compared_o   <= 0;
      hits_o       <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rsrz_pkg::REG_OUT_WIDTH:  width_q  = cfg_data_i[10:0];
          rsrz_pkg::REG_OUT_HEIGHT: height_q = cfg_data_i[10:0];
          rsrz_pkg::REG_INV_ZOOM:   zoom_q   = cfg_data_i[12:0];
          rsrz_pkg::REG_COS_ANGLE:  cos_q    = cfg_data_i;
          rsrz_pkg::REG_SIN_ANGLE:  sin_q    = cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, got hit %0d luminance %0d",
                   $time, hit_o, luminance_o);
        end else begin
          want = expected_q.pop_front();
          compared++;
          if (hit_o !== want.hit) begin
            fails++;
            $display("%0t: hit mismatch, expected %0d, got %0d", $time, want.hit, hit_o);
          end
          if (luminance_o !== want.luminance) begin
            fails++;
            $display("%0t: luminance mismatch, expected %0d, got %0d",
                     $time, want.luminance, luminance_o);
          end
        end
      end

      if (in_valid_i && !in_stall_o) begin
        if (cmd_i == rsrz_pkg::CMD_LOAD) begin
          paint_run(palette_index_i, run_length_i);
        end else begin
          want = sample_pixel(pixel_x_i, pixel_y_i);
          if (want.hit) hits++;
          expected_q.push_back(want);
        end
      end

      fail_count_o <= fails;
      pending_o    <= expected_q.size();
      compared_o   <= compared;
      hits_o       <= hits;
    end
  end

endmodule

@@ verif/tb_rle_sprite_rotozoom_sampler_core.sv @@
// ----------------------------------------------------------------------------
// tb_rle_sprite_rotozoom_sampler_core
// Self-checking bench for the rotate-zoom sprite sampler. A short directed
// sequence covers field extremes, empty and high palette indices, zero runs,
// a zero and an over-range inverse zoom and writes to unused register slots.
// Random phases then fill the sprite from run-length loads, overrun it, and
// sample it under extreme and random register settings while both sides of
// the item and result channels idle and stall at random. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rle_sprite_rotozoom_sampler_core;

  localparam int unsigned SPRITE_W       = 64;
  localparam int unsigned SPRITE_H       = 64;
  localparam int unsigned SPRITE_PIXELS  = SPRITE_W * SPRITE_H;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned PHASE_ITEMS    = 80;
  // Settle time must outlast the longest load, a run of 255 pixels, with a margin
  localparam int unsigned SETTLE_CYCLES  = 300;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;

  // Register slots beyond the implemented ones; writes there must be ignored
  localparam logic [rsrz_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
  localparam logic [rsrz_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  typedef enum int unsigned {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_TOGGLE
  } sink_mode_e;

  // Every input of the block starts at a known value
  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_stall;
  logic                            cmd         = rsrz_pkg::CMD_LOAD;
  logic [2:0]                      palette     = '0;
  logic [7:0]                      run_len     = '0;
  logic [9:0]                      pix_x       = '0;
  logic [9:0]                      pix_y       = '0;
  logic                            out_valid;
  logic                            out_stall   = 1'b0;
  logic                            hit;
  logic [7:0]                      luminance;
  logic                            cfg_valid   = 1'b0;
  logic                            cfg_ready;
  logic [rsrz_pkg::CFG_IDX_W-1:0]  cfg_index   = rsrz_pkg::REG_OUT_WIDTH;
  logic [rsrz_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
  logic                            holdoff_req = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;
  int unsigned hits;

  // Stimulus bookkeeping, and a shadow of the registers used to aim samples
  int unsigned loads_sent    = 0;
  int unsigned samples_sent  = 0;
  int unsigned settings_used = 0;
  int unsigned pixels_loaded = 0;
  int unsigned burst_left    = 0;
  int          cur_width     = int'(rsrz_pkg::OUT_WIDTH_RST);
  int          cur_height    = int'(rsrz_pkg::OUT_HEIGHT_RST);
  int          cur_zoom      = int'(rsrz_pkg::INV_ZOOM_RST);

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rle_sprite_rotozoom_sampler_core #(
    .SPRITE_W (SPRITE_W),
    .SPRITE_H (SPRITE_H)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .palette_index_i (palette),
    .run_length_i    (run_len),
    .pixel_x_i       (pix_x),
    .pixel_y_i       (pix_y),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hit_o           (hit),
    .luminance_o     (luminance),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  rle_sprite_rotozoom_sampler_checker #(
    .SPRITE_W (SPRITE_W),
    .SPRITE_H (SPRITE_H)
  ) checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .cmd_i           (cmd),
    .palette_index_i (palette),
    .run_length_i    (run_len),
    .pixel_x_i       (pix_x),
    .pixel_y_i       (pix_y),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .hit_o           (hit),
    .luminance_o     (luminance),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .compared_o      (compared),
    .hits_o          (hits)
  );

  // Watchdog: abandon the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: change stall behaviour every so often. Once the stimulus
  // raises holdoff_req, hold the channel stalled for a long stretch so that
  // results pile up inside the block and its input stalls as well.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned span;
    int unsigned hold_left;
    bit          holdoff_taken;
    hold_left     = 0;
    holdoff_taken = 1'b0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(posedge clk);
        if (holdoff_req && !holdoff_taken) begin
          holdoff_taken = 1'b1;
          hold_left     = HOLDOFF_CYCLES;
        end
        if (hold_left != 0) begin
          out_stall <= 1'b1;
          hold_left--;
        end else begin
          case (mode)
            SINK_OPEN:  out_stall <= 1'b0;
            SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            SINK_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:    out_stall <= !out_stall;
          endcase
        end
      end
    end
  end

  // Offer one item and hold it until the block takes it. Leave valid high so
  // that a following item can go out back to back.
  task automatic send_item(logic op, logic [2:0] pal, logic [7:0] run,
                           logic [9:0] x, logic [9:0] y);
    cmd      <= op;
    palette  <= pal;
    run_len  <= run;
    pix_x    <= x;
    pix_y    <= y;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == rsrz_pkg::CMD_LOAD) begin
      loads_sent++;
      pixels_loaded += 32'(run);
    end else begin
      samples_sent++;
    end
  endtask

  // Unused fields carry random junk, which the block must ignore
  task automatic send_load(logic [2:0] pal, logic [7:0] run);
    send_item(rsrz_pkg::CMD_LOAD, pal, run, 10'($urandom_range(0, 1023)),
              10'($urandom_range(0, 1023)));
  endtask

  task automatic send_sample(logic [9:0] x, logic [9:0] y);
    send_item(rsrz_pkg::CMD_SAMPLE, 3'($urandom_range(0, 7)),
              8'($urandom_range(0, 255)), x, y);
  endtask

  // Write one register and keep the shadow copy in step
  task automatic write_reg(logic [rsrz_pkg::CFG_IDX_W-1:0] idx,
                           logic [rsrz_pkg::CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      rsrz_pkg::REG_OUT_WIDTH:  cur_width  = int'(data[10:0]);
      rsrz_pkg::REG_OUT_HEIGHT: cur_height = int'(data[10:0]);
      rsrz_pkg::REG_INV_ZOOM:   cur_zoom   = int'(data[12:0]);
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] w, logic [15:0] h, logic [15:0] z,
                               logic [15:0] c, logic [15:0] s);
    write_reg(rsrz_pkg::REG_OUT_WIDTH, w);
    write_reg(rsrz_pkg::REG_OUT_HEIGHT, h);
    write_reg(rsrz_pkg::REG_INV_ZOOM, z);
    write_reg(rsrz_pkg::REG_COS_ANGLE, c);
    write_reg(rsrz_pkg::REG_SIN_ANGLE, s);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Stop offering items, wait for every outstanding result, then let any
  // load that yields no result run to completion before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bursts of random length separated by random gaps; a zero gap joins bursts
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
  endtask

  function automatic logic [9:0] aim(int centre, int reach);
    int v;
    v = centre + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // Aim two thirds of the samples at the part of the output image that maps
  // onto the sprite; spread the rest over the whole coordinate range
  task automatic random_sample();
    int zc;
    int reach;
    zc    = (cur_zoom == 0) ? 1
          : ((cur_zoom > int'(rsrz_pkg::INV_ZOOM_MAX)) ? int'(rsrz_pkg::INV_ZOOM_MAX)
                                                      : cur_zoom);
    reach = int'(SPRITE_W * 512) / zc + 2;
    if ($urandom_range(0, 2) == 0) begin
      send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
    end else begin
      send_sample(aim(cur_width / 2, reach), aim(cur_height / 2, reach));
    end
  endtask

  // Mostly short runs for spatial detail, some long ones, a few empty
  function automatic logic [7:0] pick_run();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'd0;
    if (roll <= 5) return 8'($urandom_range(1, 16));
    return 8'($urandom_range(17, 255));
  endfunction

  // One phase of random traffic. While the sprite is filling, loads and
  // samples interleave; once full, loads are rare and only exercise the drop.
  // Dropped and empty loads do not count toward the quota.
  task automatic run_phase(int unsigned quota, bit fill, int holdoff_at);
    int unsigned done;
    bit          was_full;
    logic [7:0]  run;
    done = 0;
    while (done < quota || (fill && pixels_loaded < SPRITE_PIXELS)) begin
      pace();
      if (int'(done) == holdoff_at) holdoff_req <= 1'b1;
      was_full = (pixels_loaded >= SPRITE_PIXELS);
      if ($urandom_range(0, 99) < (was_full ? 5 : 55)) begin
        run = pick_run();
        send_load(3'($urandom_range(0, 7)), run);
        if (!was_full && run != 0) done++;
      end else begin
        random_sample();
        done++;
      end
    end
  endtask

  initial begin : stimulus
    // Hold reset from the start, then release it for good
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: the centre is inside but transparent; far corner misses
    send_sample(10'd40, 10'd25);
    send_sample(10'd0, 10'd0);
    send_sample(10'd1023, 10'd1023);
    // Zero run writes nothing; then every palette index, longest run included
    send_load(3'd3, 8'd0);
    send_load(3'd1, 8'd255);
    send_load(3'd0, 8'd20);
    send_load(3'd7, 8'd9);
    send_load(3'd6, 8'd1);
    send_load(3'd2, 8'd128);
    send_load(3'd3, 8'd127);
    send_load(3'd4, 8'd64);
    send_load(3'd5, 8'd33);
    // Rows reached from the top of the output image; columns either side of
    // the centre check truncation toward zero
    send_sample(10'd40, 10'd0);
    send_sample(10'd39, 10'd1);
    send_sample(10'd41, 10'd2);
    send_sample(10'd0, 10'd2);
    send_sample(10'd79, 10'd1);
    send_sample(10'd1023, 10'd0);
    send_sample(10'd0, 10'd1023);

    // Zero inverse zoom maps everything onto the centre; unused slots ignored
    settle();
    write_reg(rsrz_pkg::REG_INV_ZOOM, 16'h0000);
    write_reg(REG_UNUSED_FIRST, 16'hFFFF);
    write_reg(REG_UNUSED_LAST, 16'h0001);
    cfg_valid <= 1'b0;
    send_sample(10'd1023, 10'd0);
    send_sample(10'd0, 10'd1023);

    // Inverse zoom beyond the floor is clamped
    settle();
    write_reg(rsrz_pkg::REG_INV_ZOOM, 16'hFFFF);
    cfg_valid <= 1'b0;
    send_sample(10'd45, 10'd30);
    send_sample(10'd20, 10'd10);

    // Random phases: fill first, then extreme settings, then random ones
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: apply_setting(16'd80, 16'd50, 16'd256, 16'd16384, 16'd0);
        1: apply_setting(16'd1024, 16'd1024, 16'd256, 16'd0, 16'd16384);
        2: apply_setting(16'd1, 16'd1, 16'd1, 16'hC000, 16'd0);
        3: apply_setting(16'hFFFF, 16'hF800, 16'd5120, 16'h7FFF, 16'h8000);
        4: apply_setting(16'd1024, 16'd1, 16'hFFFF, 16'h8000, 16'h7FFF);
        default: begin
          apply_setting(16'($urandom_range(1, 1024)), 16'($urandom_range(1, 1024)),
                        16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 5120)
                                                        : $urandom_range(64, 768)),
                        16'($urandom_range(0, 32768) - 16384),
                        16'($urandom_range(0, 32768) - 16384));
        end
      endcase
      // Phase two carries the long receiver hold-off
      run_phase(PHASE_ITEMS, phase == 0, (phase == 2) ? 20 : -1);
    end

    // Drain and let the block go quiet before the verdict
    settle();
    $display("Covered %0d load and %0d sample transactions under %0d register settings.",
             loads_sent, samples_sent, settings_used);
    $display("Compared %0d results, %0d predicted inside the sprite, %0d errors.",
             compared, hits, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
